FILE: src/cch_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the compass heading block.
package cch_pkg;

  // Action carried with each input transfer.
  typedef enum logic [1:0] {
    ACT_CAL_START  = 2'd0,
    ACT_CAL_SAMPLE = 2'd1,
    ACT_CAL_FINISH = 2'd2,
    ACT_HEADING    = 2'd3
  } cch_action_t;

  // Configuration register indexes (byte address divided by four).
  localparam logic REG_DECLINATION = 1'b0;
  localparam logic REG_ACCURACY    = 1'b1;

  // Default parameter values.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Field widths.
  localparam int FIELD_W = 16;  // raw sample field
  localparam int CORR_W  = 18;  // 2*sample - offset sum
  localparam int OFF_W   = 17;  // offset sum, twice the offset
  localparam int PRESCALE = 24; // vector scale-up before the rotations
  localparam int CW      = 45;  // rotation datapath width, with gain headroom
  localparam int ZW      = 26;  // angle accumulator, 1/65536 degree
  localparam int TW      = 35;  // heading before the wrap
  localparam int STEP_W  = 5;   // rotation step index, table has 23 nonzero entries
  localparam int ATAN_W  = 22;
  localparam int OUT_W   = 24;  // result tdata width

  localparam logic signed [ZW-1:0] ANGLE_90 = 26'sd5898240;
  localparam logic signed [TW-1:0] FULL_TURN = 35'sd2359296000;
  localparam logic [31:0] FULL_TURN_U = 32'd2359296000;

  // Decoded commands from the controller to the datapath.
  typedef struct packed {
    logic              cal_start;
    logic              cal_sample;
    logic              cal_finish;
    logic              load;
    logic              corr;
    logic              prep;
    logic              iter;
    logic              scale;
    logic              wrap;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } cch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } cch_stat_t;

  // atan(2^-i) in degrees scaled by 65536.
  function automatic logic [ATAN_W-1:0] cch_atan(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/cch_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: declination and north accuracy.
module cch_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic signed [15:0]  declination_cdeg,
  output logic [14:0]         accuracy_cdeg
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      declination_cdeg <= 16'sd0;
      accuracy_cdeg    <= 15'd500;
    end else if (wr_en) begin
      case (reg_idx)
        cch_pkg::REG_DECLINATION: declination_cdeg <= $signed(pwdata[15:0]);
        cch_pkg::REG_ACCURACY:    accuracy_cdeg    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      cch_pkg::REG_DECLINATION: prdata = 32'(declination_cdeg);
      cch_pkg::REG_ACCURACY:    prdata = {17'd0, accuracy_cdeg};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/cch_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences calibration and heading computation.
module cch_ctrl #(
  parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_ready,
  output cch_pkg::cch_cmd_t   cmd,
  input  cch_pkg::cch_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORR,
    S_PREP,
    S_ITER,
    S_SCALE,
    S_WRAP,
    S_OUT
  } state_t;

  localparam logic [cch_pkg::STEP_W-1:0] LAST_STEP = cch_pkg::STEP_W'(CORDIC_STEPS - 1);

  state_t                    state;
  logic [cch_pkg::STEP_W-1:0] step;
  cch_pkg::cch_action_t      action;
  logic                      accept;

  assign action   = cch_pkg::cch_action_t'(in_action);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // State and rotation step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && action == cch_pkg::ACT_HEADING) begin
            state <= S_CORR;
          end
        end
        S_CORR: begin
          state <= S_PREP;
        end
        S_PREP: begin
          step  <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (step == LAST_STEP) begin
            state <= S_SCALE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SCALE: begin
          state <= S_WRAP;
        end
        S_WRAP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd            = '0;
    cmd.cal_start  = accept && action == cch_pkg::ACT_CAL_START;
    cmd.cal_sample = accept && action == cch_pkg::ACT_CAL_SAMPLE;
    cmd.cal_finish = accept && action == cch_pkg::ACT_CAL_FINISH;
    cmd.load       = accept && action == cch_pkg::ACT_HEADING;
    cmd.corr       = (state == S_CORR);
    cmd.prep       = (state == S_PREP);
    cmd.iter       = (state == S_ITER);
    cmd.scale      = (state == S_SCALE);
    cmd.wrap       = (state == S_WRAP);
    cmd.out_load   = (state == S_OUT) && stat.out_free;
    cmd.step       = step;
  end

endmodule

FILE: src/cch_datapath.sv
`timescale 1ns / 1ps
// Datapath: min/max tracking, offset correction, CORDIC vectoring and heading wrap.
module cch_datapath #(
  parameter int SAMPLE_BITS = cch_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cch_pkg::cch_cmd_t               cmd,
  output cch_pkg::cch_stat_t              stat,
  input  logic [cch_pkg::FIELD_W-1:0]     mag_x,
  input  logic [cch_pkg::FIELD_W-1:0]     mag_y,
  input  logic signed [15:0]              declination_cdeg,
  input  logic [14:0]                     accuracy_cdeg,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cch_pkg::OUT_W-1:0]       m_tdata
);

  localparam int FW = cch_pkg::FIELD_W;
  localparam int RW = cch_pkg::CORR_W;
  localparam int CW = cch_pkg::CW;
  localparam int ZW = cch_pkg::ZW;
  localparam int TW = cch_pkg::TW;

  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [FW-1:0] x_in, y_in;
  logic signed [FW-1:0] min_x, max_x, min_y, max_y;
  logic signed [cch_pkg::OFF_W-1:0] off_x, off_y;
  logic signed [FW-1:0] x_reg, y_reg;
  logic signed [RW-1:0] cx, cy, cx_next, cy_next;
  logic                 zero_vec;
  logic signed [RW:0]   pa, pb;
  logic signed [ZW-1:0] pz;
  logic signed [CW-1:0] a, b, da, db;
  logic signed [ZW-1:0] z, ang;
  logic signed [16:0]   base;
  logic signed [TW-1:0] total, z_term, b_term, t_plus, t_minus;
  logic [31:0]          r_reg;
  logic [15:0]          heading;
  logic [16:0]          acc17;
  logic                 at_north, turn_cw;

  // Samples taken from the low SAMPLE_BITS bits, sign-extended.
  assign xs   = mag_x[SAMPLE_BITS-1:0];
  assign ys   = mag_y[SAMPLE_BITS-1:0];
  assign x_in = FW'(xs);
  assign y_in = FW'(ys);

  // Calibration extremes and offset sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= 16'sh7FFF;
      max_x <= 16'sh8000;
      min_y <= 16'sh7FFF;
      max_y <= 16'sh8000;
      off_x <= '0;
      off_y <= '0;
    end else if (cmd.cal_start) begin
      min_x <= 16'sh7FFF;
      max_x <= 16'sh8000;
      min_y <= 16'sh7FFF;
      max_y <= 16'sh8000;
    end else if (cmd.cal_sample) begin
      if (x_in < min_x) min_x <= x_in;
      if (x_in > max_x) max_x <= x_in;
      if (y_in < min_y) min_y <= y_in;
      if (y_in > max_y) max_y <= y_in;
    end else if (cmd.cal_finish) begin
      off_x <= cch_pkg::OFF_W'(min_x) + cch_pkg::OFF_W'(max_x);
      off_y <= cch_pkg::OFF_W'(min_y) + cch_pkg::OFF_W'(max_y);
    end
  end

  // Hard-iron correction: twice the sample minus the offset sum.
  assign cx_next = $signed({x_reg[FW-1], x_reg, 1'b0}) - RW'(off_x);
  assign cy_next = $signed({y_reg[FW-1], y_reg, 1'b0}) - RW'(off_y);

  // Quarter-turn into the right half-plane (Y is the real part).
  always_comb begin
    pa = (RW+1)'(cy);
    pb = (RW+1)'(cx);
    pz = '0;
    if (cy < 0) begin
      if (cx >= 0) begin
        pa = (RW+1)'(cx);
        pb = -(RW+1)'(cy);
        pz = cch_pkg::ANGLE_90;
      end else begin
        pa = -(RW+1)'(cx);
        pb = (RW+1)'(cy);
        pz = -cch_pkg::ANGLE_90;
      end
    end
  end

  // One vectoring rotation per cycle.
  assign da  = b >>> cmd.step;
  assign db  = a >>> cmd.step;
  assign ang = $signed(ZW'(cch_pkg::cch_atan(cmd.step)));

  // Heading scaling and wrap candidates.
  assign base    = 17'sd18000 + 17'(declination_cdeg);
  assign z_term  = zero_vec ? '0 : TW'(z) * TW'(100);
  assign b_term  = TW'(base) <<< 16;
  assign t_plus  = total + cch_pkg::FULL_TURN;
  assign t_minus = total - cch_pkg::FULL_TURN;

  // Angle pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg <= x_in;
      y_reg <= y_in;
    end
    if (cmd.corr) begin
      cx       <= cx_next;
      cy       <= cy_next;
      zero_vec <= (cx_next == '0) && (cy_next == '0);
    end
    if (cmd.prep) begin
      a <= CW'(pa) <<< cch_pkg::PRESCALE;
      b <= CW'(pb) <<< cch_pkg::PRESCALE;
      z <= pz;
    end
    if (cmd.iter) begin
      if (!b[CW-1]) begin
        a <= a + da;
        b <= b - db;
        z <= z + ang;
      end else begin
        a <= a - da;
        b <= b + db;
        z <= z - ang;
      end
    end
    if (cmd.scale) begin
      total <= z_term + b_term;
    end
    if (cmd.wrap) begin
      if (total < 0) begin
        r_reg <= 32'(t_plus);
      end else if (total >= cch_pkg::FULL_TURN) begin
        r_reg <= 32'(t_minus);
      end else begin
        r_reg <= 32'(total);
      end
    end
  end

  // North band and pivot direction.
  assign heading  = r_reg[31:16];
  assign acc17    = {2'b00, accuracy_cdeg};
  assign at_north = ({1'b0, heading} + acc17 >= 17'd36000) || ({1'b0, heading} <= acc17);
  assign turn_cw  = !(({1'b0, heading} > acc17) && (heading < 16'd18000));

  // Output register: holds one result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'd0, turn_cw, at_north, heading};
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

`ifndef SYNTH
  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  // The wrapped angle is always below a full turn.
  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.wrap) |-> (r_reg < cch_pkg::FULL_TURN_U))
    else $error("wrapped heading out of range");

  // Every offered heading lies in [0, 36000).
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] < 16'd36000))
    else $error("heading out of range");
`endif

endmodule

FILE: src/compass_calibrate_heading.sv
`timescale 1ns / 1ps
// Top level of the compass calibration and heading block.
// Each input transfer carries an action in s_tuser and an X/Y magnetometer
// pair in s_tdata. Start, sample and finish calibration actions produce no
// result. A heading sample runs through an iterative CORDIC that performs
// one rotation per cycle; it occupies the block through correction,
// preparation, the rotations, scaling, wrap and an output load that waits for
// a free output register, before s_tready rises again. The result waits in
// that register, so the next item is taken while a finished heading still
// waits for its transfer. The user must write configuration through the APB
// port only while the block is idle; the block does not enforce this.
module compass_calibrate_heading #(
  parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = cch_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [15:0] mag_x, [31:16] mag_y
  input  logic [1:0]  s_tuser,  // [1:0] action
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [15:0] heading_cdeg, [16] at_north, [17] turn_cw, rest zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cch_pkg::cch_cmd_t  cmd;
  cch_pkg::cch_stat_t stat;
  logic signed [15:0] declination_cdeg;
  logic [14:0]        accuracy_cdeg;

  // Configuration registers.
  cch_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .declination_cdeg (declination_cdeg),
    .accuracy_cdeg    (accuracy_cdeg)
  );

  // Sequencer.
  cch_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and result register.
  cch_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .mag_x            (s_tdata[15:0]),
    .mag_y            (s_tdata[31:16]),
    .declination_cdeg (declination_cdeg),
    .accuracy_cdeg    (accuracy_cdeg),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the compass calibration and heading block.
module tb;

  localparam int     ROT_STEPS    = 16;
  localparam int     QUIET_LIMIT  = 4000;
  localparam int     DRAIN_CYCLES = 30;
  localparam longint DEG_FRAC     = 65536;
  localparam longint TURN_FIXED   = 64'sd36000 * 65536;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_LONG} ready_mode_t;

  typedef struct {
    logic [15:0] heading_cdeg;
    logic        at_north;
    logic        turn_cw;
  } heading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] mag_x, [31:16] mag_y
  logic [1:0]  s_tuser = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] heading_cdeg, [16] at_north, [17] turn_cw
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Arctangent of 2^-i in degrees times 65536, one entry per rotation.
  longint rot_atan [ROT_STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115};

  // Predicted calibration state and configuration.
  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] decl_cdeg;
  logic [14:0]        tol_cdeg;

  heading_t    heading_q[$];
  heading_t    oldest;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned stall_tick = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  bit          send_gaps = 1'b0;
  int          burst_left = 0;
  int          items_sent = 0;

  compass_calibrate_heading dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern, chosen per phase.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (ready_mode)
      RDY_ALWAYS:   m_tready <= 1'b1;
      RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: m_tready <= ((stall_tick % 7) < 4);
      default:      m_tready <= ((stall_tick % 64) >= 40);
    endcase
  end

  // Updates the calibration state for one accepted item and, for a heading
  // sample, works out the heading, the north flag and the pivot direction.
  function automatic bit compass_predict(input cch_pkg::cch_action_t act,
                                         input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         output heading_t h);
    longint re, im, t, da, db, ang, total, wrapped, tol, hd;
    h = '{16'd0, 1'b0, 1'b0};
    case (act)
      cch_pkg::ACT_CAL_START: begin
        lo_x = 16'sh7fff;
        hi_x = 16'sh8000;
        lo_y = 16'sh7fff;
        hi_y = 16'sh8000;
      end
      cch_pkg::ACT_CAL_SAMPLE: begin
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
      end
      cch_pkg::ACT_CAL_FINISH: begin
        sum_x = 17'(longint'(lo_x) + longint'(hi_x));
        sum_y = 17'(longint'(lo_y) + longint'(hi_y));
      end
      default: begin
        // Y is the real part and X the imaginary part of the corrected vector.
        re = 2 * longint'(y) - longint'(sum_y);
        im = 2 * longint'(x) - longint'(sum_x);
        ang = 0;
        if (re != 0 || im != 0) begin
          re = re * 16777216;
          im = im * 16777216;
          // Fold the left half-plane into the right one first.
          if (re < 0) begin
            t = re;
            if (im >= 0) begin
              re = im;
              im = -t;
              ang = 90 * DEG_FRAC;
            end else begin
              re = -im;
              im = t;
              ang = -90 * DEG_FRAC;
            end
          end
          for (int i = 0; i < ROT_STEPS; i++) begin
            da = im >>> i;
            db = re >>> i;
            if (im >= 0) begin
              re += da;
              im -= db;
              ang += rot_atan[i];
            end else begin
              re -= da;
              im += db;
              ang -= rot_atan[i];
            end
          end
        end
        // Offset by 180 degrees plus declination, wrap, truncate to centidegrees.
        total = ang * 100 + (18000 + longint'(decl_cdeg)) * DEG_FRAC;
        wrapped = total % TURN_FIXED;
        if (wrapped < 0) wrapped += TURN_FIXED;
        hd = wrapped >>> 16;
        tol = longint'(tol_cdeg);
        h.heading_cdeg = 16'(hd);
        h.at_north = (hd >= 36000 - tol) || (hd <= tol);
        h.turn_cw = !((hd > tol) && (hd < 18000));
      end
    endcase
    return act == cch_pkg::ACT_HEADING;
  endfunction

  // A sample value near a center, clamped to the field range.
  function automatic logic signed [15:0] near_value(input longint center, input int spread);
    longint v;
    v = center + longint'(int'($urandom_range(0, 2 * spread))) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Sends one item, records its prediction once the transfer happens, then
  // applies the burst and gap pacing.
  task automatic send_sample(input cch_pkg::cch_action_t act, input logic signed [15:0] x,
                             input logic signed [15:0] y);
    heading_t h;
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {y, x};
    do @(posedge clk); while (!s_tready);
    if (compass_predict(act, x, y, h)) heading_q.push_back(h);
    items_sent++;
    if (send_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 8);
        gap = $urandom_range(1, 24);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == cch_pkg::REG_DECLINATION) decl_cdeg = value[15:0];
    else tol_cdeg = value[14:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops sending and waits until every predicted heading has come out,
  // then lets the block finish any trailing calibration item.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (heading_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Headings with the reset offsets of zero, including the field extremes.
  task automatic test_reset_defaults();
    ready_mode = RDY_RANDOM;
    send_gaps = 1'b1;
    send_sample(cch_pkg::ACT_HEADING, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_HEADING, 16'sh7fff, 16'sh8000);
    send_sample(cch_pkg::ACT_HEADING, 16'sh8000, 16'sh7fff);
    send_sample(cch_pkg::ACT_HEADING, 16'sh8000, 16'sh8000);
    send_sample(cch_pkg::ACT_HEADING, 16'sd1, 16'sd0);
    send_sample(cch_pkg::ACT_HEADING, 16'sd0, -16'sd1);
  endtask

  // Calibration runs: extremes, finish with no samples, samples outside a run.
  task automatic test_calibration_cases();
    send_sample(cch_pkg::ACT_CAL_START, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_CAL_SAMPLE, 16'sh7fff, 16'sh8000);
    send_sample(cch_pkg::ACT_CAL_SAMPLE, 16'sh8000, 16'sh7fff);
    send_sample(cch_pkg::ACT_CAL_FINISH, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_HEADING, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_CAL_START, 16'sh7fff, 16'sh7fff);
    send_sample(cch_pkg::ACT_CAL_FINISH, 16'sh8000, 16'sh8000);
    send_sample(cch_pkg::ACT_HEADING, 16'sh8000, 16'sd0);
    // No start here: the samples still widen the tracked range.
    send_sample(cch_pkg::ACT_CAL_SAMPLE, 16'sd100, -16'sd200);
    send_sample(cch_pkg::ACT_CAL_SAMPLE, -16'sd300, 16'sd50);
    send_sample(cch_pkg::ACT_CAL_FINISH, 16'sd0, 16'sd0);
    // The corrected vector is zero for this one.
    send_sample(cch_pkg::ACT_HEADING, -16'sd100, -16'sd75);
  endtask

  // A zero vector gives a heading of 18000 plus the declination (mod 36000), so each
  // setting lands on a chosen edge of the north band or the pivot split.
  task automatic test_north_band();
    logic [31:0] decl_list [8];
    logic [31:0] tol_list [8];
    decl_list = '{32'(-18000), 32'(-17500), 32'(-17499), 32'(-1),
                  32'(17500), 32'(32767), 32'(-32768), 32'hA5A5_4650};
    tol_list = '{32'd0, 32'd500, 32'd500, 32'd500,
                 32'd500, 32'd18000, 32'd32767, 32'hFFFF_C650};
    send_sample(cch_pkg::ACT_CAL_START, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_CAL_SAMPLE, 16'sd0, 16'sd0);
    send_sample(cch_pkg::ACT_CAL_FINISH, 16'sd0, 16'sd0);
    for (int k = 0; k < 8; k++) begin
      drain();
      write_reg(cch_pkg::REG_DECLINATION, decl_list[k]);
      write_reg(cch_pkg::REG_ACCURACY, tol_list[k]);
      send_sample(cch_pkg::ACT_HEADING, 16'sd0, 16'sd0);
    end
  endtask

  // Random phases: mostly calibration runs followed by headings near the
  // calibrated center, with bare headings and random noise mixed in.
  task automatic test_random_traffic();
    int target, kind, spread;
    logic signed [15:0] cx, cy;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      write_reg(cch_pkg::REG_DECLINATION, $urandom_range(0, 1) ? $urandom :
                32'(int'($urandom_range(0, 36000)) - 18000));
      write_reg(cch_pkg::REG_ACCURACY, $urandom_range(0, 1) ? $urandom :
                32'($urandom_range(0, 18000)));
      ready_mode = ready_mode_t'(phase % 4);
      send_gaps = (phase != 0 && phase != 5);
      target = items_sent + 150;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
          0: spread = 2;
          1: spread = 64;
          2: spread = 4000;
          default: spread = 40000;
        endcase
        if (kind < 6) begin
          cx = 16'($urandom);
          cy = 16'($urandom);
          send_sample(cch_pkg::ACT_CAL_START, 16'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 10))
            send_sample(cch_pkg::ACT_CAL_SAMPLE, near_value(cx, spread),
                        near_value(cy, spread));
          send_sample(cch_pkg::ACT_CAL_FINISH, 16'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 6))
            send_sample(cch_pkg::ACT_HEADING, near_value(cx, spread),
                        near_value(cy, spread));
        end else if (kind < 8) begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1))
              send_sample(cch_pkg::ACT_HEADING, 16'($urandom), 16'($urandom));
            else
              send_sample(cch_pkg::ACT_HEADING, near_value(longint'(sum_x) >>> 1, spread),
                          near_value(longint'(sum_y) >>> 1, spread));
          end
        end else begin
          repeat ($urandom_range(1, 4))
            send_sample(cch_pkg::cch_action_t'($urandom_range(0, 3)), 16'($urandom),
                        16'($urandom));
        end
      end
    end
  endtask

  // Result checker: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (heading_q.size() == 0) begin
        $error("result with no heading pending: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        oldest = heading_q.pop_front();
        if (m_tdata[15:0] !== oldest.heading_cdeg) begin
          $error("heading_cdeg: expected %0d, got %0d", oldest.heading_cdeg, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[16] !== oldest.at_north) begin
          $error("at_north: expected %0b, got %0b", oldest.at_north, m_tdata[16]);
          mismatches++;
        end
        if (m_tdata[17] !== oldest.turn_cw) begin
          $error("turn_cw: expected %0b, got %0b", oldest.turn_cw, m_tdata[17]);
          mismatches++;
        end
        if (m_tdata[23:18] !== 6'd0) begin
          $error("pad: expected %0d, got %0d", 6'd0, m_tdata[23:18]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    lo_x = 16'sh7fff;
    hi_x = 16'sh8000;
    lo_y = 16'sh7fff;
    hi_y = 16'sh8000;
    sum_x = '0;
    sum_y = '0;
    decl_cdeg = '0;
    tol_cdeg = 15'd500;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_calibration_cases();
    test_north_band();
    test_random_traffic();
    drain();
    if (mismatches == 0 && heading_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
